FILE: sv/affine_matrix_inverse_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the affine matrix inverse core
// Clocked on i_clk; the first form is gated off while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef AFFINE_MATRIX_INVERSE_CORE_DEFINES_SVH
`define AFFINE_MATRIX_INVERSE_CORE_DEFINES_SVH

// checked only out of reset
`define AMXI_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define AMXI_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

FILE: sv/amxi_pkg.sv
// ----------------------------------------------------------------------------
// amxi_pkg
// Widths, constants and types shared by the affine matrix inverse core.
// ----------------------------------------------------------------------------
package amxi_pkg;

    localparam int EW      = 32;              // element width
    localparam int FB      = 16;              // fraction bits
    localparam int NROW    = 3;
    localparam int NCOL    = 4;
    localparam int NLANE   = 4;               // three inverse columns + translation
    localparam int ROW_W   = 2;

    localparam int PW      = 2 * EW;          // 2x2 minor product
    localparam int CW      = PW + 1;          // cofactor
    localparam int HW      = 2 * EW + 1;      // partial product of cofactor split
    localparam int PPW     = 3 * EW + 1;      // cofactor * element
    localparam int DW      = 3 * EW + 3;      // determinant / translation sum
    localparam int NCW     = CW + 2 * FB;     // scaled cofactor numerator
    localparam int NTW     = DW + FB;         // scaled translation numerator
    localparam int NW      = (NTW > NCW) ? NTW : NCW;
    localparam int RW      = ((NW > DW + EW) ? NW : DW + EW) + 1;

    localparam int IN_W    = NROW * NCOL * EW;
    localparam int IN_TW   = ((IN_W + 7) / 8) * 8;
    localparam int OUT_W   = NLANE * EW;
    localparam int OUT_TW  = ((OUT_W + 7) / 8) * 8;
    localparam int USER_W  = ROW_W + 1;

    localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(NROW - 1);

    localparam logic [EW:0] LIM_NEG = (EW+1)'(1) << (EW - 1);
    localparam logic [EW:0] LIM_POS = LIM_NEG - (EW+1)'(1);

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic             singular;
    } t_side;

endpackage

FILE: sv/amxi_div.sv
// ----------------------------------------------------------------------------
// amxi_div
// Four-lane pipelined restoring divider, one quotient bit per stage, with
// overflow detection, saturation and sign restore at the output register.
// ----------------------------------------------------------------------------
module amxi_div (
    input  logic                                           i_clk,
    input  logic                                           i_rst_n,
    input  logic                                           i_en,
    input  logic                                           i_valid,
    input  amxi_pkg::t_side                                i_side,
    input  logic [amxi_pkg::NLANE-1:0][amxi_pkg::NW-1:0]   i_num,
    input  logic [amxi_pkg::NLANE-1:0]                     i_neg,
    input  logic [amxi_pkg::DW-1:0]                        i_dmag,
    output logic                                           o_valid,
    output amxi_pkg::t_side                                o_side,
    output logic [amxi_pkg::NLANE-1:0][amxi_pkg::EW-1:0]   o_q
);

    localparam int EW = amxi_pkg::EW;
    localparam int NL = amxi_pkg::NLANE;
    localparam int RW = amxi_pkg::RW;
    localparam int DW = amxi_pkg::DW;

    logic                  r_v    [EW+1];
    amxi_pkg::t_side       r_side [EW+1];
    logic [DW-1:0]         r_d    [EW+1];
    logic [RW-1:0]         r_rem  [EW+1][NL];
    logic [EW-1:0]         r_q    [EW+1][NL];
    logic [NL-1:0]         r_neg  [EW+1];
    logic [NL-1:0]         r_ovf  [EW+1];

    logic                  r_ov;
    amxi_pkg::t_side       r_oside;
    logic [NL-1:0][EW-1:0] r_oq;

    logic [RW-1:0]         w_rem  [EW][NL];
    logic                  w_geq  [EW][NL];
    logic [NL-1:0][EW-1:0] w_res;

    // stage k settles quotient bit EW-1-k
    always_comb begin
        logic [RW-1:0] sh;
        for (int k = 0; k < EW; k++) begin
            sh = RW'(r_d[k]) << (EW - 1 - k);
            for (int l = 0; l < NL; l++) begin
                w_geq[k][l] = (r_rem[k][l] >= sh);
                w_rem[k][l] = w_geq[k][l] ? (r_rem[k][l] - sh) : r_rem[k][l];
            end
        end
    end

    always_comb begin
        logic [EW:0] lim;
        logic [EW:0] qx;
        logic [EW:0] mag;
        for (int l = 0; l < NL; l++) begin
            lim = r_neg[EW][l] ? amxi_pkg::LIM_NEG : amxi_pkg::LIM_POS;
            qx  = {1'b0, r_q[EW][l]};
            mag = (r_ovf[EW][l] || (qx >= lim)) ? lim : qx;
            if (r_side[EW].singular) begin
                w_res[l] = '0;
            end else if (r_neg[EW][l]) begin
                w_res[l] = EW'(-mag);
            end else begin
                w_res[l] = EW'(mag);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= EW; k++) begin
                r_v[k] <= 1'b0;
            end
            r_ov <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
            for (int k = 0; k < EW; k++) begin
                r_v[k+1] <= r_v[k];
            end
            r_ov <= r_v[EW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d[0]    <= i_dmag;
            r_side[0] <= i_side;
            r_neg[0]  <= i_neg;
            for (int l = 0; l < NL; l++) begin
                r_rem[0][l] <= RW'(i_num[l]);
                r_q[0][l]   <= '0;
                // quotient needs more than EW bits
                r_ovf[0][l] <= (RW'(i_num[l]) >= (RW'(i_dmag) << EW));
            end
            for (int k = 0; k < EW; k++) begin
                r_d[k+1]    <= r_d[k];
                r_side[k+1] <= r_side[k];
                r_neg[k+1]  <= r_neg[k];
                r_ovf[k+1]  <= r_ovf[k];
                for (int l = 0; l < NL; l++) begin
                    r_rem[k+1][l] <= w_rem[k][l];
                    r_q[k+1][l]   <= {r_q[k][l][EW-2:0], w_geq[k][l]};
                end
            end
            r_oside <= r_side[EW];
            r_oq    <= w_res;
        end
    end

    assign o_valid = r_ov;
    assign o_side  = r_oside;
    assign o_q     = r_oq;

endmodule

FILE: sv/affine_matrix_inverse_core.sv
// ----------------------------------------------------------------------------
// affine_matrix_inverse_core
// Inverse of a 3x4 affine transform in signed Q16.16, one row per item out.
// Rows leave in order 0, 1, 2. Each matrix is issued as three rows from
//   the input holding register into the shared row pipeline; a new
//   matrix is taken as its last row issues.
// Reset: synchronous active low; clears the valid bits, data is not reset.
// ----------------------------------------------------------------------------
module affine_matrix_inverse_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // a00 a01 a02 t0 a10 a11 a12 t1 a20 a21 a22 t2, 32 bits each, a00 lowest
    input  logic [amxi_pkg::IN_TW-1:0]    s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // inv_col0 inv_col1 inv_col2 inv_trans, 32 bits each, inv_col0 lowest
    output logic [amxi_pkg::OUT_TW-1:0]   m_tdata,
    output logic                          m_tlast,
    // row_index [1:0], singular [2]
    output logic [amxi_pkg::USER_W-1:0]   m_tuser
);

    localparam int EW  = amxi_pkg::EW;
    localparam int FB  = amxi_pkg::FB;
    localparam int PW  = amxi_pkg::PW;
    localparam int CW  = amxi_pkg::CW;
    localparam int HW  = amxi_pkg::HW;
    localparam int PPW = amxi_pkg::PPW;
    localparam int DW  = amxi_pkg::DW;
    localparam int NW  = amxi_pkg::NW;
    localparam int NL  = amxi_pkg::NLANE;
    localparam int RWD = amxi_pkg::ROW_W;

    logic w_en;
    logic w_accept;
    logic w_issue;

    // input holding register; linear columns rotate left once per row issue
    logic signed [EW-1:0] r_m [3][4];
    logic signed [EW-1:0] n_m [3][4];
    logic                 r_hv, n_hv;
    logic [RWD-1:0]       r_cnt, n_cnt;

    logic                 r1_v, r2_v, r3_v, r4_v, r5_v, r6_v;
    logic [RWD-1:0]       r1_row, r2_row, r3_row, r4_row, r5_row;

    logic signed [PW-1:0] r1_pa [3];
    logic signed [PW-1:0] r1_pb [3];
    logic signed [EW-1:0] r1_col [3];
    logic signed [EW-1:0] r1_t [3];

    logic signed [CW-1:0] r2_cof [3];
    logic signed [EW-1:0] r2_col [3];
    logic signed [EW-1:0] r2_t [3];

    logic signed [HW-1:0] r3_dh [3];
    logic signed [HW-1:0] r3_dl [3];
    logic signed [HW-1:0] r3_th [3];
    logic signed [HW-1:0] r3_tl [3];
    logic [CW-1:0]        r3_cmag [3];
    logic [2:0]           r3_cneg;

    logic signed [PPW-1:0] r4_dp [3];
    logic signed [PPW-1:0] r4_tp [3];
    logic [CW-1:0]         r4_cmag [3];
    logic [2:0]            r4_cneg;

    logic signed [DW-1:0]  r5_det;
    logic signed [DW-1:0]  r5_s;
    logic [CW-1:0]         r5_cmag [3];
    logic [2:0]            r5_cneg;

    logic [NL-1:0][NW-1:0] r6_num;
    logic [NL-1:0]         r6_neg;
    logic [DW-1:0]         r6_dmag;
    amxi_pkg::t_side       r6_side;

    logic                  w_ovalid;
    amxi_pkg::t_side       w_oside;
    logic [NL-1:0][EW-1:0] w_q;

    assign w_en     = !m_tvalid || m_tready;
    assign w_issue  = r_hv && w_en;
    assign s_tready = !r_hv || (w_en && (r_cnt == amxi_pkg::ROW_LAST));
    assign w_accept = s_tvalid && s_tready;

    always_comb begin
        n_m   = r_m;
        n_hv  = r_hv;
        n_cnt = r_cnt;
        if (w_accept) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 4; c++) begin
                    n_m[r][c] = s_tdata[(r*amxi_pkg::NCOL + c)*EW +: EW];
                end
            end
            n_hv  = 1'b1;
            n_cnt = '0;
        end else if (w_issue) begin
            for (int r = 0; r < 3; r++) begin
                n_m[r][0] = r_m[r][1];
                n_m[r][1] = r_m[r][2];
                n_m[r][2] = r_m[r][0];
            end
            n_cnt = r_cnt + RWD'(1);
            if (r_cnt == amxi_pkg::ROW_LAST) begin
                n_hv = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hv  <= 1'b0;
            r_cnt <= '0;
            r1_v  <= 1'b0;
            r2_v  <= 1'b0;
            r3_v  <= 1'b0;
            r4_v  <= 1'b0;
            r5_v  <= 1'b0;
            r6_v  <= 1'b0;
        end else begin
            r_hv  <= n_hv;
            r_cnt <= n_cnt;
            if (w_en) begin
                r1_v <= r_hv;
                r2_v <= r1_v;
                r3_v <= r2_v;
                r4_v <= r3_v;
                r5_v <= r4_v;
                r6_v <= r5_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_m <= n_m;
    end

    // column r sits in column 0 after r rotations, so the minors use fixed taps
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_row <= r_cnt;
            for (int c = 0; c < 3; c++) begin
                r1_pa[c]  <= r_m[(c+1)%3][1] * r_m[(c+2)%3][2];
                r1_pb[c]  <= r_m[(c+1)%3][2] * r_m[(c+2)%3][1];
                r1_col[c] <= r_m[c][0];
                r1_t[c]   <= r_m[c][3];
            end

            r2_row <= r1_row;
            for (int c = 0; c < 3; c++) begin
                r2_cof[c] <= CW'(r1_pa[c]) - CW'(r1_pb[c]);
                r2_col[c] <= r1_col[c];
                r2_t[c]   <= r1_t[c];
            end

            // cofactor split: signed upper half, unsigned lower half
            r3_row <= r2_row;
            for (int c = 0; c < 3; c++) begin
                r3_dh[c]   <= $signed(r2_cof[c][CW-1:EW]) * r2_col[c];
                r3_dl[c]   <= $signed({1'b0, r2_cof[c][EW-1:0]}) * r2_col[c];
                r3_th[c]   <= $signed(r2_cof[c][CW-1:EW]) * r2_t[c];
                r3_tl[c]   <= $signed({1'b0, r2_cof[c][EW-1:0]}) * r2_t[c];
                r3_cmag[c] <= r2_cof[c][CW-1] ? CW'(-r2_cof[c]) : CW'(r2_cof[c]);
                r3_cneg[c] <= r2_cof[c][CW-1];
            end

            r4_row  <= r3_row;
            r4_cneg <= r3_cneg;
            for (int c = 0; c < 3; c++) begin
                r4_dp[c]   <= (PPW'(r3_dh[c]) <<< EW) + PPW'(r3_dl[c]);
                r4_tp[c]   <= (PPW'(r3_th[c]) <<< EW) + PPW'(r3_tl[c]);
                r4_cmag[c] <= r3_cmag[c];
            end

            // diagonal of adj * A gives the determinant from this row alone
            r5_row  <= r4_row;
            r5_cneg <= r4_cneg;
            r5_cmag <= r4_cmag;
            r5_det  <= DW'(r4_dp[0]) + DW'(r4_dp[1]) + DW'(r4_dp[2]);
            r5_s    <= DW'(r4_tp[0]) + DW'(r4_tp[1]) + DW'(r4_tp[2]);

            r6_side.row      <= r5_row;
            r6_side.singular <= (r5_det == '0);
            r6_dmag <= r5_det[DW-1] ? DW'(-r5_det) : DW'(r5_det);
            for (int c = 0; c < 3; c++) begin
                r6_num[c] <= NW'(r5_cmag[c]) << (2 * FB);
                r6_neg[c] <= r5_cneg[c] ^ r5_det[DW-1];
            end
            // inverse translation is -s
            r6_num[NL-1] <= NW'(r5_s[DW-1] ? DW'(-r5_s) : DW'(r5_s)) << FB;
            r6_neg[NL-1] <= (!r5_s[DW-1] && (r5_s != '0)) ^ r5_det[DW-1];
        end
    end

    amxi_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r6_v),
        .i_side  (r6_side),
        .i_num   (r6_num),
        .i_neg   (r6_neg),
        .i_dmag  (r6_dmag),
        .o_valid (w_ovalid),
        .o_side  (w_oside),
        .o_q     (w_q)
    );

    assign m_tvalid = w_ovalid;
    assign m_tdata  = amxi_pkg::OUT_TW'(w_q);
    assign m_tlast  = (w_oside.row == amxi_pkg::ROW_LAST);
    assign m_tuser  = {w_oside.singular, w_oside.row};

endmodule

FILE: sv/amxi_chk.sv
// ----------------------------------------------------------------------------
// amxi_chk
// Port-level checks on the affine matrix inverse core, bound to the top.
// ----------------------------------------------------------------------------
`include "affine_matrix_inverse_core_defines.svh"

module amxi_chk (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [amxi_pkg::OUT_TW-1:0]   m_tdata,
    input logic                          m_tlast,
    input logic [amxi_pkg::USER_W-1:0]   m_tuser
);

    // out of reset: nothing pending, input open
    `AMXI_ASSERT_ALWAYS(a_reset_clears, !i_rst_n |=> (!m_tvalid && s_tready), "reset not clean")

    `AMXI_ASSERT(a_hold_on_stall, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)), "output item changed under stall")

    `AMXI_ASSERT(a_last_row, m_tvalid |-> (m_tlast == (m_tuser[1:0] == amxi_pkg::ROW_LAST)), "tlast not on final row")

    // singular matrix gives all-zero rows
    `AMXI_ASSERT(a_singular_zero, (m_tvalid && m_tuser[2]) |-> (m_tdata == '0), "singular row not zero")

endmodule

bind affine_matrix_inverse_core amxi_chk u_amxi_chk (.*);

FILE: tb/sv/affine_matrix_inverse_core_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// affine_matrix_inverse_core_checker
// Watches both streams, predicts the three inverse rows of each accepted
// matrix with wide exact arithmetic and compares them in order.
// ----------------------------------------------------------------------------
module affine_matrix_inverse_core_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    input  logic                          i_s_tready,
    input  logic [amxi_pkg::IN_TW-1:0]    i_s_tdata,
    input  logic                          i_m_tvalid,
    input  logic                          i_m_tready,
    input  logic [amxi_pkg::OUT_TW-1:0]   i_m_tdata,
    input  logic                          i_m_tlast,
    input  logic [amxi_pkg::USER_W-1:0]   i_m_tuser,
    output int                            o_fail_count,
    output int                            o_rows_pending
);

    localparam int EW    = amxi_pkg::EW;
    localparam int FB    = amxi_pkg::FB;
    localparam int ROW_W = amxi_pkg::ROW_W;
    localparam int IN_TW = amxi_pkg::IN_TW;

    typedef logic signed [255:0] t_wide;

    typedef struct {
        logic [ROW_W-1:0] row;
        logic [EW-1:0]    col [3];
        logic [EW-1:0]    trans;
        logic             singular;
        logic             last;
    } t_inv_row;

    t_inv_row inv_rows_q [$];
    int       fails;
    int       pending;

    assign o_fail_count   = fails;
    assign o_rows_pending = pending;

    // truncating divide, saturated to the element range
    function automatic logic [EW-1:0] quot_sat(t_wide num, t_wide den);
        t_wide q;
        t_wide hi;
        t_wide lo;
        hi = (t_wide'(1) <<< (EW - 1)) - 1;
        lo = -(t_wide'(1) <<< (EW - 1));
        q  = num / den;
        if (q > hi) q = hi;
        if (q < lo) q = lo;
        return q[EW-1:0];
    endfunction

    task automatic predict_inverse(logic [IN_TW-1:0] mat);
        t_wide    m [3][4];
        t_wide    cof [3][3];
        t_wide    det;
        t_wide    tsum;
        t_inv_row r;
        int       i, j, r1, r2, c1, c2;
        for (i = 0; i < 3; i++)
            for (j = 0; j < 4; j++)
                m[i][j] = t_wide'($signed(mat[(i*4+j)*EW +: EW]));
        for (i = 0; i < 3; i++)
            for (j = 0; j < 3; j++) begin
                r1 = (j + 1) % 3; r2 = (j + 2) % 3;
                c1 = (i + 1) % 3; c2 = (i + 2) % 3;
                cof[i][j] = m[r1][c1] * m[r2][c2] - m[r1][c2] * m[r2][c1];
            end
        det = m[0][0] * cof[0][0] + m[0][1] * cof[1][0] + m[0][2] * cof[2][0];
        for (i = 0; i < 3; i++) begin
            r.row      = ROW_W'(i);
            r.last     = (i == 2);
            r.singular = (det == 0);
            tsum = -(cof[i][0] * m[0][3] + cof[i][1] * m[1][3] + cof[i][2] * m[2][3]);
            for (j = 0; j < 3; j++)
                r.col[j] = r.singular ? '0 : quot_sat(cof[i][j] <<< (2 * FB), det);
            r.trans = r.singular ? '0 : quot_sat(tsum <<< FB, det);
            inv_rows_q.push_back(r);
        end
    endtask

    task automatic compare_field(string name, logic [EW-1:0] exp_v, logic [EW-1:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %h, got %h", name, exp_v, act_v);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin
        t_inv_row e;
        if (!i_rst_n) begin
            fails = 0;
            inv_rows_q.delete();
        end else begin
            if (i_s_tvalid && i_s_tready) predict_inverse(i_s_tdata);
            if (i_m_tvalid && i_m_tready) begin
                if (inv_rows_q.size() == 0) begin
                    $error("row result with nothing expected");
                    fails++;
                end else begin
                    e = inv_rows_q.pop_front();
                    compare_field("row_index", EW'(e.row), EW'(i_m_tuser[ROW_W-1:0]));
                    compare_field("singular", EW'(e.singular), EW'(i_m_tuser[ROW_W]));
                    compare_field("last_row", EW'(e.last), EW'(i_m_tlast));
                    compare_field("inv_col0", e.col[0], i_m_tdata[0 +: EW]);
                    compare_field("inv_col1", e.col[1], i_m_tdata[EW +: EW]);
                    compare_field("inv_col2", e.col[2], i_m_tdata[2*EW +: EW]);
                    compare_field("inv_trans", e.trans, i_m_tdata[3*EW +: EW]);
                end
            end
        end
        pending = inv_rows_q.size();
    end
endmodule

FILE: tb/sv/affine_matrix_inverse_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// affine_matrix_inverse_core_test
// Feeds directed and random affine matrices with random gaps and output
// stalls; the checker predicts and compares every inverse row.
// ----------------------------------------------------------------------------
module affine_matrix_inverse_core_test;

    localparam int EW       = amxi_pkg::EW;
    localparam int IN_TW    = amxi_pkg::IN_TW;
    localparam int OUT_TW   = amxi_pkg::OUT_TW;
    localparam int USER_W   = amxi_pkg::USER_W;

    localparam int ONE      = 32'h0001_0000;
    localparam int LATENCY  = 60;
    localparam int MAX_CYC  = 400000;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [IN_TW-1:0]   s_tdata = '0;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [OUT_TW-1:0]  m_tdata;
    logic               m_tlast;
    logic [USER_W-1:0]  m_tuser;
    int                 fail_count;
    int                 rows_pending;
    int                 cycles = 0;

    always #1 clk = ~clk;

    affine_matrix_inverse_core uut (
        .i_clk(clk), .i_rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tlast(m_tlast), .m_tuser(m_tuser)
    );

    affine_matrix_inverse_core_checker chk (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_s_tvalid(s_tvalid), .i_s_tready(s_tready), .i_s_tdata(s_tdata),
        .i_m_tvalid(m_tvalid), .i_m_tready(m_tready), .i_m_tdata(m_tdata),
        .i_m_tlast(m_tlast), .i_m_tuser(m_tuser),
        .o_fail_count(fail_count), .o_rows_pending(rows_pending)
    );

    function automatic int gap_len();
        if ($urandom_range(0, 15) == 0) return $urandom_range(8, 30);
        if ($urandom_range(0, 2) == 0) return 0;
        return $urandom_range(0, 3);
    endfunction

    // receiver stalls, with stall-free stretches
    always @(posedge clk) begin
        if (!rst_n) m_tready <= 1'b0;
        else if ((cycles / 500) % 4 == 1) m_tready <= 1'b1;
        else m_tready <= ($urandom_range(0, 15) == 0) ? 1'b0 :
                         ($urandom_range(0, 3) != 0);
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > MAX_CYC) begin
            $display("** affine_matrix_inverse_core: FAILED **");
            $finish;
        end
    end

    // one matrix, then a random gap; back-to-back when the gap is zero
    task automatic send_matrix(logic [IN_TW-1:0] mat, bit burst);
        int g;
        s_tvalid <= 1'b1;
        s_tdata  <= mat;
        do @(posedge clk); while (!s_tready);
        g = (burst || (cycles / 700) % 5 == 2) ? 0 : gap_len();
        if (g > 0) begin
            s_tvalid <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    function automatic logic [IN_TW-1:0] pack(int v [12]);
        logic [IN_TW-1:0] p;
        p = '0;
        for (int i = 0; i < 12; i++) p[i*EW +: EW] = v[i];
        return p;
    endfunction

    function automatic int rnd_elem(int kind);
        case (kind)
            0: return $urandom;
            1: return $signed($urandom_range(0, 8 * ONE)) - 4 * ONE;
            2: return $signed($urandom_range(0, 512)) - 256;
            default: begin
                case ($urandom_range(0, 5))
                    0: return 32'h7fff_ffff;
                    1: return 32'h8000_0000;
                    2: return 0;
                    3: return ONE;
                    4: return -ONE;
                    default: return $urandom;
                endcase
            end
        endcase
    endfunction

    initial begin
        int v [12];
        int k, sel;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // identity, scaled, zero, singular rows, extremes
        v = '{ONE, 0, 0, 0, 0, ONE, 0, 0, 0, 0, ONE, 0};
        send_matrix(pack(v), 0);
        v = '{ONE, 0, 0, 5 * ONE, 0, ONE, 0, -3 * ONE, 0, 0, ONE, 32'h7fff_ffff};
        send_matrix(pack(v), 0);
        v = '{2 * ONE, 0, 0, ONE, 0, ONE / 2, 0, ONE, 0, 0, -4 * ONE, ONE};
        send_matrix(pack(v), 0);
        v = '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0};
        send_matrix(pack(v), 0);
        v = '{ONE, 2 * ONE, 3 * ONE, 7, 2 * ONE, 4 * ONE, 6 * ONE, 9, 1, 5, 8, 3};
        send_matrix(pack(v), 1);
        v = '{1, 0, 0, 32'h8000_0000, 0, 1, 0, 32'h7fff_ffff, 0, 0, 1, 32'h8000_0000};
        send_matrix(pack(v), 1);
        v = '{-1, 0, 0, 32'h7fff_ffff, 0, -1, 0, 32'h8000_0000, 0, 0, -1, 1};
        send_matrix(pack(v), 0);
        for (int i = 0; i < 12; i++) v[i] = 32'h7fff_ffff;
        send_matrix(pack(v), 0);
        for (int i = 0; i < 12; i++) v[i] = 32'h8000_0000;
        send_matrix(pack(v), 0);
        v = '{32'h8000_0000, 0, 0, -1, 0, 32'h7fff_ffff, 0, 1,
              0, 0, 32'h8000_0000, 32'h7fff_ffff};
        send_matrix(pack(v), 1);
        v = '{32'h7fff_ffff, 32'h8000_0000, 0, 0, 32'h8000_0000, 32'h7fff_ffff, 0, 0,
              0, 0, 1, -1};
        send_matrix(pack(v), 0);
        for (int i = 0; i < 12; i++) v[i] = -1;
        v[0] = 1; v[5] = 1; v[10] = 1;
        send_matrix(pack(v), 0);

        // hold off until every row has drained
        s_tvalid <= 1'b0;
        do @(posedge clk); while (rows_pending != 0);

        for (int n = 0; n < 260; n++) begin
            k = $urandom_range(0, 3);
            for (int i = 0; i < 12; i++) v[i] = rnd_elem(k);
            sel = $urandom_range(0, 9);
            if (sel == 0) begin
                // duplicated row makes it singular
                for (int i = 0; i < 3; i++) v[8 + i] = v[i];
            end else if (sel == 1) begin
                for (int i = 0; i < 3; i++) v[4 * i + 1] = 0;
            end
            send_matrix(pack(v), $urandom_range(0, 3) == 0);
            if (n == 130) begin
                s_tvalid <= 1'b0;
                do @(posedge clk); while (rows_pending != 0);
            end
        end
        s_tvalid <= 1'b0;

        do @(posedge clk); while (rows_pending != 0);
        repeat (LATENCY) @(posedge clk);
        if (fail_count == 0 && rows_pending == 0)
            $display("** affine_matrix_inverse_core: PASSED **");
        else
            $display("** affine_matrix_inverse_core: FAILED **");
        $finish;
    end
endmodule
